### src/mpcs_pkg.sv
// ----------------------------------------------------------------------------
// mpcs_pkg
// Shared types, constants and helpers of the multilayer projection coreness
// scorer.
// ----------------------------------------------------------------------------
package mpcs_pkg;

  // Default sizes
  localparam int unsigned MaxNodesDef  = 64;
  localparam int unsigned MaxLayersDef = 4;
  localparam int unsigned MaxEdgesDef  = 1024;

  // Field widths fixed by the interface
  localparam int unsigned NodeW  = 6;
  localparam int unsigned LayerW = 2;
  localparam int unsigned ScoreW = 16;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 7;

  // Command codes
  localparam logic CMD_LOAD = 1'b0;

  // Register indexes
  localparam logic [CfgIdxW-1:0] REG_NODE_COUNT  = 1'b0;
  localparam logic [CfgIdxW-1:0] REG_LAYER_COUNT = 1'b1;

  // One stored adjacency entry
  typedef struct packed {
    logic [NodeW-1:0]  src_node;
    logic [LayerW-1:0] src_layer;
    logic [NodeW-1:0]  dst_node;
    logic [LayerW-1:0] dst_layer;
  } edge_t;

  // Row sorter control
  typedef struct packed {
    logic shift;
    logic pass;
    logic odd;
  } sort_ctrl_t;

  // Sequencer states
  typedef enum logic [4:0] {
    S_IDLE,
    S_CLR,
    S_CNT_ERD,
    S_CNT_EUSE,
    S_CNT_CRD,
    S_CNT_CINC,
    S_SRT_RD,
    S_SRT_LD,
    S_SRT_PASS,
    S_SRT_WR,
    S_NODE,
    S_DEG_RD,
    S_DEG_USE,
    S_DEG_DONE,
    S_HCLR,
    S_FIL_ERD,
    S_FIL_EUSE,
    S_FIL_CRD,
    S_FIL_CUSE,
    S_FIL_HRD,
    S_FIL_HINC,
    S_SCAN_RD,
    S_SCAN_USE,
    S_ACC,
    S_NEXT_L,
    S_OUT
  } state_e;

  // Edge lies inside the nodes and layers in use
  function automatic logic edge_ok(edge_t e, logic [7:0] nc, logic [7:0] lc);
    return ({2'b00, e.src_node} < nc) && ({2'b00, e.dst_node} < nc) &&
           ({6'b0, e.src_layer} < lc) && ({6'b0, e.dst_layer} < lc);
  endfunction

endpackage

### src/mpcs_if.sv
// ----------------------------------------------------------------------------
// mpcs interfaces
// Valid/ready channels for edges, scores and register writes.
// ----------------------------------------------------------------------------
interface mpcs_edge_if;
  logic                      valid;
  logic                      ready;
  logic                      cmd;
  logic [mpcs_pkg::NodeW-1:0]  src_node;
  logic [mpcs_pkg::LayerW-1:0] src_layer;
  logic [mpcs_pkg::NodeW-1:0]  dst_node;
  logic [mpcs_pkg::LayerW-1:0] dst_layer;
  logic                      last_edge;

  modport source (output valid, cmd, src_node, src_layer, dst_node, dst_layer,
                  last_edge, input ready);
  modport sink   (input valid, cmd, src_node, src_layer, dst_node, dst_layer,
                  last_edge, output ready);
endinterface

interface mpcs_score_if;
  logic                        valid;
  logic                        ready;
  logic [mpcs_pkg::NodeW-1:0]  node_index;
  logic [mpcs_pkg::ScoreW-1:0] score;
  logic                        last_score;

  modport source (output valid, node_index, score, last_score, input ready);
  modport sink   (input valid, node_index, score, last_score, output ready);
endinterface

interface mpcs_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [mpcs_pkg::CfgIdxW-1:0]  index;
  logic [mpcs_pkg::CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### src/mpcs_ram.sv
// ----------------------------------------------------------------------------
// mpcs_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module mpcs_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### src/mpcs_row_sort.sv
// ----------------------------------------------------------------------------
// mpcs_row_sort
// Row buffer for one node-layer's link counts; shifts a row in and out and
// runs odd-even transposition passes to sort it in descending order.
// ----------------------------------------------------------------------------
module mpcs_row_sort #(
  parameter int unsigned LANES = 4,
  parameter int unsigned CW    = 11
) (
  input  logic                 clk_i,
  input  mpcs_pkg::sort_ctrl_t ctrl_i,
  input  logic [CW-1:0]        din_i,
  output logic [CW-1:0]        dout_o
);
  import mpcs_pkg::*;

  logic [CW-1:0] row_q [LANES];
  logic [CW-1:0] row_d [LANES];

  // One compare-exchange pass over the pairs of the chosen parity
  always_comb begin
    row_d = row_q;
    for (int j = 0; j + 1 < LANES; j++) begin
      if ((((j % 2) == 1) == ctrl_i.odd) && (row_q[j] < row_q[j+1])) begin
        row_d[j]   = row_q[j+1];
        row_d[j+1] = row_q[j];
      end
    end
  end

  // Row buffer
  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      for (int j = 0; j + 1 < LANES; j++) begin
        row_q[j] <= row_q[j+1];
      end
      row_q[LANES-1] <= din_i;
    end else if (ctrl_i.pass) begin
      row_q <= row_d;
    end
  end

  assign dout_o = row_q[0];

endmodule

### src/multilayer_pci_score_core.sv
// ----------------------------------------------------------------------------
// multilayer_pci_score_core
// Loads multilayer adjacency entries, builds sorted per-layer link counts and
// emits one saturating h-index score per node in use.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake     | payload
//  edge_i   | in  | valid/ready   | cmd, src_node, src_layer, dst_node,
//           |     |               | dst_layer, last_edge
//  score_o  | out | valid/ready   | node_index, score, last_score
//  cfg_i    | in  | valid/ready   | index, data (node_count, layer_count)
//
//  Loading accepts one edge per cycle. After the last edge the sequencer
//  clears the count RAM, counts links, sorts every row, then per node-layer
//  scans the edges once for the degree and, per rank, clears deg histogram
//  entries, rescans the edges and walks the histogram. edge_i is not ready
//  during compute; a stalled score holds the sequencer in place.
//  Reset clears control state only; no RAM clearing pass after reset.
// ----------------------------------------------------------------------------
module multilayer_pci_score_core #(
  parameter int unsigned MAX_NODES  = mpcs_pkg::MaxNodesDef,
  parameter int unsigned MAX_LAYERS = mpcs_pkg::MaxLayersDef,
  parameter int unsigned MAX_EDGES  = mpcs_pkg::MaxEdgesDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  mpcs_edge_if.sink    edge_i,
  mpcs_score_if.source score_o,
  mpcs_cfg_if.sink     cfg_i
);
  import mpcs_pkg::*;

  localparam int unsigned NCW    = $clog2(MAX_NODES + 1);
  localparam int unsigned LCW    = $clog2(MAX_LAYERS + 1);
  localparam int unsigned EW     = $clog2(MAX_EDGES + 1);
  localparam int unsigned EAW    = $clog2(MAX_EDGES);
  localparam int unsigned ROWS   = MAX_NODES * MAX_LAYERS;
  localparam int unsigned CDEPTH = ROWS * MAX_LAYERS;
  localparam int unsigned CAW    = $clog2(CDEPTH);
  localparam int unsigned CRW    = CAW + 1;
  localparam int unsigned HDEPTH = MAX_EDGES + 1;
  localparam int unsigned HAW    = $clog2(HDEPTH);

  // State and counters
  state_e             state_q, state_d;
  logic [6:0]         node_count_q;
  logic [2:0]         layer_count_q;
  logic [NCW-1:0]     nc_q, i_q;
  logic [LCW-1:0]     lc_q, l_q, n_q, j_q, p_q;
  logic [EW-1:0]      total_q, e_q, deg_q, k_q, cum_q, h_q, v_q;
  logic [CRW-1:0]     r_q;
  logic [ScoreW-1:0]  acc_q;
  edge_t              edge_q;

  // Memory ports
  logic               edge_we;
  logic [EAW-1:0]     edge_waddr;
  edge_t              edge_wdata, edge_rdata;
  logic [EW-1:0]      cnt_rdata, cnt_wdata;
  logic               cnt_we;
  logic [CAW-1:0]     cnt_waddr, cnt_raddr;
  logic [EW-1:0]      hist_rdata, hist_wdata;
  logic               hist_we;
  logic [HAW-1:0]     hist_waddr, hist_raddr;
  sort_ctrl_t         sort_ctrl;
  logic [EW-1:0]      sort_dout;

  // Derived conditions
  logic               in_acc, out_acc, load_ok, rd_ok, rd_match;
  logic [NCW-1:0]     nc_new;
  logic [LCW-1:0]     lc_new;
  logic [CAW-1:0]     row_addr, cnt_idx, nbr_idx;
  logic [EW-1:0]      v_new, cum_sum;
  logic [16:0]        acc_sum;
  logic               l_last, n_last, i_last, e_end;

  assign in_acc  = edge_i.valid && edge_i.ready;
  assign out_acc = score_o.valid && score_o.ready;
  assign load_ok = in_acc && (edge_i.cmd == CMD_LOAD);

  // Clamp registers to their usable range
  always_comb begin
    if (node_count_q == 7'd0) begin
      nc_new = NCW'(1);
    end else if (8'(node_count_q) > 8'(MAX_NODES)) begin
      nc_new = NCW'(MAX_NODES);
    end else begin
      nc_new = NCW'(node_count_q);
    end
    if (layer_count_q == 3'd0) begin
      lc_new = LCW'(1);
    end else if (8'(layer_count_q) > 8'(MAX_LAYERS)) begin
      lc_new = LCW'(MAX_LAYERS);
    end else begin
      lc_new = LCW'(layer_count_q);
    end
  end

  assign rd_ok    = edge_ok(edge_rdata, 8'(nc_q), 8'(lc_q));
  assign rd_match = rd_ok && (8'(edge_rdata.src_node) == 8'(i_q)) &&
                    (8'(edge_rdata.src_layer) == 8'(l_q));
  assign e_end    = (e_q == total_q);
  assign l_last   = (l_q == LCW'(lc_q - LCW'(1)));
  assign n_last   = (n_q == LCW'(lc_q - LCW'(1)));
  assign i_last   = (i_q == NCW'(nc_q - NCW'(1)));

  // Count RAM addresses
  assign row_addr = CAW'(32'(r_q) * MAX_LAYERS + 32'(j_q));
  assign cnt_idx  = CAW'(32'(edge_q.src_node) * (MAX_LAYERS * MAX_LAYERS) +
                         32'(edge_q.src_layer) * MAX_LAYERS + 32'(edge_q.dst_layer));
  assign nbr_idx  = CAW'(32'(edge_q.dst_node) * (MAX_LAYERS * MAX_LAYERS) +
                         32'(edge_q.dst_layer) * MAX_LAYERS + 32'(n_q));

  // Shared arithmetic
  assign v_new   = (cnt_rdata > deg_q) ? deg_q : cnt_rdata;
  assign cum_sum = cum_q + hist_rdata;
  assign acc_sum = 17'(acc_q) + 17'(h_q);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:     if (load_ok && edge_i.last_edge) state_d = S_CLR;
      S_CLR:      if (r_q == CRW'(CDEPTH - 1)) state_d = S_CNT_ERD;
      S_CNT_ERD:  state_d = e_end ? S_SRT_RD : S_CNT_EUSE;
      S_CNT_EUSE: state_d = rd_ok ? S_CNT_CRD : S_CNT_ERD;
      S_CNT_CRD:  state_d = S_CNT_CINC;
      S_CNT_CINC: state_d = S_CNT_ERD;
      S_SRT_RD:   state_d = S_SRT_LD;
      S_SRT_LD:   state_d = (j_q == LCW'(MAX_LAYERS - 1)) ? S_SRT_PASS : S_SRT_RD;
      S_SRT_PASS: if (p_q == LCW'(MAX_LAYERS - 1)) state_d = S_SRT_WR;
      S_SRT_WR: begin
        if (j_q == LCW'(MAX_LAYERS - 1)) begin
          state_d = (r_q == CRW'(ROWS - 1)) ? S_NODE : S_SRT_RD;
        end
      end
      S_NODE:     state_d = S_DEG_RD;
      S_DEG_RD:   state_d = e_end ? S_DEG_DONE : S_DEG_USE;
      S_DEG_USE:  state_d = S_DEG_RD;
      S_DEG_DONE: state_d = (deg_q == '0) ? S_NEXT_L : S_HCLR;
      S_HCLR:     if (k_q == deg_q) state_d = S_FIL_ERD;
      S_FIL_ERD:  state_d = e_end ? S_SCAN_RD : S_FIL_EUSE;
      S_FIL_EUSE: state_d = rd_match ? S_FIL_CRD : S_FIL_ERD;
      S_FIL_CRD:  state_d = S_FIL_CUSE;
      S_FIL_CUSE: state_d = (v_new != '0) ? S_FIL_HRD : S_FIL_ERD;
      S_FIL_HRD:  state_d = S_FIL_HINC;
      S_FIL_HINC: state_d = S_FIL_ERD;
      S_SCAN_RD:  state_d = S_SCAN_USE;
      S_SCAN_USE: begin
        if ((cum_sum >= k_q) || (k_q == EW'(1))) begin
          state_d = S_ACC;
        end else begin
          state_d = S_SCAN_RD;
        end
      end
      S_ACC:      state_d = n_last ? S_NEXT_L : S_HCLR;
      S_NEXT_L:   state_d = l_last ? S_OUT : S_DEG_RD;
      S_OUT:      if (out_acc) state_d = i_last ? S_IDLE : S_NODE;
      default:    state_d = S_IDLE;
    endcase
  end

  // Memory and handshake controls
  always_comb begin
    edge_we    = 1'b0;
    edge_waddr = total_q[EAW-1:0];
    edge_wdata = '{src_node: edge_i.src_node, src_layer: edge_i.src_layer,
                   dst_node: edge_i.dst_node, dst_layer: edge_i.dst_layer};
    cnt_we     = 1'b0;
    cnt_waddr  = cnt_idx;
    cnt_wdata  = cnt_rdata + EW'(1);
    cnt_raddr  = cnt_idx;
    hist_we    = 1'b0;
    hist_waddr = k_q[HAW-1:0];
    hist_wdata = '0;
    hist_raddr = k_q[HAW-1:0];
    sort_ctrl  = '{shift: 1'b0, pass: 1'b0, odd: p_q[0]};
    edge_i.ready  = 1'b0;
    score_o.valid = 1'b0;
    case (state_q)
      S_IDLE: begin
        edge_i.ready = 1'b1;
        edge_we      = load_ok && (total_q < EW'(MAX_EDGES));
      end
      S_CLR: begin
        cnt_we    = 1'b1;
        cnt_waddr = r_q[CAW-1:0];
        cnt_wdata = '0;
      end
      S_CNT_CINC: cnt_we = 1'b1;
      S_SRT_RD:   cnt_raddr = row_addr;
      S_SRT_LD:   sort_ctrl.shift = 1'b1;
      S_SRT_PASS: sort_ctrl.pass = 1'b1;
      S_SRT_WR: begin
        cnt_we          = 1'b1;
        cnt_waddr       = row_addr;
        cnt_wdata       = sort_dout;
        sort_ctrl.shift = 1'b1;
      end
      S_FIL_CRD:  cnt_raddr = nbr_idx;
      S_HCLR:     hist_we = 1'b1;
      S_FIL_HRD:  hist_raddr = v_q[HAW-1:0];
      S_FIL_HINC: begin
        hist_we    = 1'b1;
        hist_waddr = v_q[HAW-1:0];
        hist_wdata = hist_rdata + EW'(1);
      end
      S_OUT:      score_o.valid = 1'b1;
      default:    ;
    endcase
  end

  assign cfg_i.ready = 1'b1;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q  <= 7'd64;
      layer_count_q <= 3'd4;
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (cfg_i.index)
        REG_NODE_COUNT:  node_count_q  <= cfg_i.data;
        REG_LAYER_COUNT: layer_count_q <= cfg_i.data[2:0];
        default:         ;
      endcase
    end
  end

  // Edge fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
    end else if (edge_we) begin
      total_q <= total_q + EW'(1);
    end else if ((state_q == S_OUT) && out_acc && i_last) begin
      total_q <= '0;
    end
  end

  // Sequencer counters and working registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nc_q  <= '0;
      lc_q  <= '0;
      i_q   <= '0;
      l_q   <= '0;
      n_q   <= '0;
      j_q   <= '0;
      p_q   <= '0;
      e_q   <= '0;
      r_q   <= '0;
      deg_q <= '0;
      k_q   <= '0;
      cum_q <= '0;
      h_q   <= '0;
      v_q   <= '0;
      acc_q <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (load_ok && edge_i.last_edge) begin
            nc_q <= nc_new;
            lc_q <= lc_new;
            r_q  <= '0;
          end
        end
        S_CLR: begin
          r_q <= r_q + CRW'(1);
          e_q <= '0;
        end
        S_CNT_ERD: begin
          r_q <= '0;
          j_q <= '0;
        end
        S_CNT_EUSE: e_q <= e_q + EW'(1);
        S_SRT_LD: begin
          j_q <= (j_q == LCW'(MAX_LAYERS - 1)) ? '0 : j_q + LCW'(1);
          p_q <= '0;
        end
        S_SRT_PASS: p_q <= p_q + LCW'(1);
        S_SRT_WR: begin
          if (j_q == LCW'(MAX_LAYERS - 1)) begin
            j_q <= '0;
            r_q <= r_q + CRW'(1);
          end else begin
            j_q <= j_q + LCW'(1);
          end
          i_q <= '0;
        end
        S_NODE: begin
          acc_q <= '0;
          l_q   <= '0;
          e_q   <= '0;
          deg_q <= '0;
        end
        S_DEG_USE: begin
          e_q <= e_q + EW'(1);
          if (rd_match) deg_q <= deg_q + EW'(1);
        end
        S_DEG_DONE: begin
          n_q <= '0;
          k_q <= EW'(1);
        end
        S_HCLR: begin
          k_q <= k_q + EW'(1);
          e_q <= '0;
        end
        S_FIL_ERD: begin
          k_q   <= deg_q;
          cum_q <= '0;
          h_q   <= '0;
        end
        S_FIL_EUSE: e_q <= e_q + EW'(1);
        S_FIL_CUSE: v_q <= v_new;
        S_SCAN_USE: begin
          cum_q <= cum_sum;
          if (cum_sum >= k_q) begin
            h_q <= k_q;
          end else if (k_q != EW'(1)) begin
            k_q <= k_q - EW'(1);
          end
        end
        S_ACC: begin
          acc_q <= acc_sum[16] ? {ScoreW{1'b1}} : acc_sum[15:0];
          n_q   <= n_q + LCW'(1);
          k_q   <= EW'(1);
        end
        S_NEXT_L: begin
          l_q   <= l_q + LCW'(1);
          e_q   <= '0;
          deg_q <= '0;
        end
        S_OUT: if (out_acc) i_q <= i_q + NCW'(1);
        default: ;
      endcase
    end
  end

  // Edge latch for count and fill passes
  always_ff @(posedge clk_i) begin
    if ((state_q == S_CNT_EUSE) || (state_q == S_FIL_EUSE)) begin
      edge_q <= edge_rdata;
    end
  end

  assign score_o.node_index = NodeW'(i_q);
  assign score_o.score      = acc_q;
  assign score_o.last_score = i_last;

  // Stores
  mpcs_ram #(.WIDTH($bits(edge_t)), .DEPTH(MAX_EDGES)) u_edge_ram (
    .clk_i   (clk_i),
    .we_i    (edge_we),
    .waddr_i (edge_waddr),
    .wdata_i (edge_wdata),
    .raddr_i (e_q[EAW-1:0]),
    .rdata_o (edge_rdata)
  );

  mpcs_ram #(.WIDTH(EW), .DEPTH(CDEPTH)) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (cnt_waddr),
    .wdata_i (cnt_wdata),
    .raddr_i (cnt_raddr),
    .rdata_o (cnt_rdata)
  );

  mpcs_ram #(.WIDTH(EW), .DEPTH(HDEPTH)) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (hist_we),
    .waddr_i (hist_waddr),
    .wdata_i (hist_wdata),
    .raddr_i (hist_raddr),
    .rdata_o (hist_rdata)
  );

  mpcs_row_sort #(.LANES(MAX_LAYERS), .CW(EW)) u_row_sort (
    .clk_i  (clk_i),
    .ctrl_i (sort_ctrl),
    .din_i  (cnt_rdata),
    .dout_o (sort_dout)
  );

`ifndef SYNTHESIS
  // Never loading and emitting at once
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(edge_i.ready && score_o.valid))
    else $error("edge load overlaps score emission");

  // Fill count never passes the store depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= EW'(MAX_EDGES))
    else $error("edge count overflow");

  // A final edge closes the load window
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_ok && edge_i.last_edge) |=> !edge_i.ready)
    else $error("still loading after final edge");

  // Histogram walk stays within the degree
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN_USE) |-> (k_q <= deg_q && k_q != '0))
    else $error("histogram walk out of range");
`endif

endmodule
